[rtl/vlp_pkg.sv]
// Shared constants, types and helpers of the voxel light propagation block.
package vlp_pkg;

	localparam int GRID_WIDTH  = 16;
	localparam int GRID_HEIGHT = 16;
	localparam int KIND_COUNT  = 256;

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT * GRID_WIDTH;
	localparam int XB = $clog2(GRID_WIDTH);
	localparam int YB = $clog2(GRID_HEIGHT);
	localparam int CB = $clog2(CELL_COUNT);
	localparam int KB = $clog2(KIND_COUNT);
	localparam int CLR_COUNT = (CELL_COUNT > KIND_COUNT) ? CELL_COUNT : KIND_COUNT;
	localparam int CLRB = $clog2(CLR_COUNT);
	localparam int PASS_COUNT = 15;
	localparam int PB = $clog2(PASS_COUNT);

	localparam logic [3:0] FULL_LIGHT = 4'd15;

	typedef enum logic [1:0] {
		OP_PALETTE = 2'd0,
		OP_SET     = 2'd1,
		OP_RELIGHT = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		FACE_XP = 3'd0,
		FACE_XN = 3'd1,
		FACE_YP = 3'd2,
		FACE_YN = 3'd3,
		FACE_ZP = 3'd4,
		FACE_ZN = 3'd5
	} face_t;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic sky_rd;
		logic sky_pal;
		logic sky_wr;
		logic sp_rd;
		logic sp_chk;
		logic sp_nb;
		logic sp_upd;
		logic adv_face;
		logic adv_cell;
		logic q_out;
		logic r_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic sky_last;
		logic here_hi;
		logic nb_in;
		logic face_last;
		logic cell_last;
		logic pass_last;
	} sts_t;

	function automatic logic [CB-1:0] cell_index(logic [XB-1:0] x, logic [YB-1:0] y,
		logic [XB-1:0] z);
		return CB'((int'(y) * GRID_WIDTH + int'(z)) * GRID_WIDTH + int'(x));
	endfunction

endpackage

[rtl/vlp_ctrl.sv]
// Controller state machine of the voxel light propagation block.
module vlp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       opcode,
	input  vlp_pkg::sts_t    sts,
	output vlp_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             valid
);

	typedef enum logic [10:0] {
		S_CLEAR   = 11'b000_0000_0001,
		S_IDLE    = 11'b000_0000_0010,
		S_QUERY   = 11'b000_0000_0100,
		S_SKY_RD  = 11'b000_0000_1000,
		S_SKY_PAL = 11'b000_0001_0000,
		S_SKY_WR  = 11'b000_0010_0000,
		S_SP_RD   = 11'b000_0100_0000,
		S_SP_CHK  = 11'b000_1000_0000,
		S_SP_NB   = 11'b001_0000_0000,
		S_SP_UPD  = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	state_t after_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign after_cell = (sts.cell_last && sts.pass_last) ? S_DONE : S_SP_RD;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (opcode == vlp_pkg::OP_RELIGHT) state_d = S_SKY_RD;
					else if (opcode == vlp_pkg::OP_QUERY) state_d = S_QUERY;
				end
			end
			S_QUERY: begin
				cmd.q_out = 1'b1;
				state_d = S_IDLE;
			end
			S_SKY_RD: begin
				cmd.sky_rd = 1'b1;
				state_d = S_SKY_PAL;
			end
			S_SKY_PAL: begin
				cmd.sky_pal = 1'b1;
				state_d = S_SKY_WR;
			end
			S_SKY_WR: begin
				cmd.sky_wr = 1'b1;
				state_d = sts.sky_last ? S_SP_RD : S_SKY_RD;
			end
			S_SP_RD: begin
				cmd.sp_rd = 1'b1;
				state_d = S_SP_CHK;
			end
			S_SP_CHK: begin
				cmd.sp_chk = 1'b1;
				if (sts.here_hi) begin
					state_d = S_SP_NB;
				end else begin
					cmd.adv_cell = 1'b1;
					state_d = after_cell;
				end
			end
			S_SP_NB: begin
				cmd.sp_nb = 1'b1;
				if (sts.nb_in) begin
					state_d = S_SP_UPD;
				end else if (sts.face_last) begin
					cmd.adv_cell = 1'b1;
					state_d = after_cell;
				end else begin
					cmd.adv_face = 1'b1;
				end
			end
			S_SP_UPD: begin
				cmd.sp_upd = 1'b1;
				if (sts.face_last) begin
					cmd.adv_cell = 1'b1;
					state_d = after_cell;
				end else begin
					cmd.adv_face = 1'b1;
					state_d = S_SP_NB;
				end
			end
			S_DONE: begin
				cmd.r_out = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy  = (state_q != S_IDLE);
	assign valid = cmd.q_out | cmd.r_out;

endmodule

[rtl/vlp_dp.sv]
// Datapath of the voxel light propagation block: grid stores, palette and sweep counters.
module vlp_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vlp_pkg::cmd_t         cmd,
	output vlp_pkg::sts_t         sts,
	input  logic [1:0]            opcode,
	input  logic signed [8:0]     pos_x,
	input  logic signed [8:0]     pos_y,
	input  logic signed [8:0]     pos_z,
	input  logic [7:0]            kind_value,
	input  logic                  solid_flag,
	input  logic [3:0]            emission_level,
	output logic                  answer_tag,
	output logic [7:0]            voxel_kind,
	output logic [3:0]            sky_level,
	output logic [3:0]            glow_level
);

	localparam int XB = vlp_pkg::XB;
	localparam int YB = vlp_pkg::YB;
	localparam int CB = vlp_pkg::CB;
	localparam int KB = vlp_pkg::KB;
	localparam int CLRB = vlp_pkg::CLRB;
	localparam int PB = vlp_pkg::PB;

	logic [7:0] kind_mem  [vlp_pkg::CELL_COUNT];
	logic [3:0] sky_mem   [vlp_pkg::CELL_COUNT];
	logic [3:0] glow_mem  [vlp_pkg::CELL_COUNT];
	logic       solid_mem [vlp_pkg::CELL_COUNT];
	logic [4:0] pal_mem   [vlp_pkg::KIND_COUNT];

	logic [CLRB-1:0] clr_q;
	logic [XB-1:0]   x_q, z_q;
	logic [YB-1:0]   y_q;
	logic [PB-1:0]   pass_q;
	vlp_pkg::face_t  face_q;
	logic            blocked_q;
	logic [3:0]      next_q;
	logic [CB-1:0]   nb_addr_q;
	logic            kind_ok_q;
	logic            qin_q;

	logic [7:0] kind_rd;
	logic [3:0] sky_rd;
	logic [3:0] glow_rd;
	logic       solid_rd;
	logic [4:0] pal_rd;

	logic          in_grid;
	logic [CB-1:0] in_addr;
	logic [CB-1:0] cell_addr;
	logic [CB-1:0] nb_addr;
	logic          nb_in;
	logic          clr_cell, clr_pal;
	logic          pal_idx_ok;
	logic          cell_solid, blk;
	logic [3:0]    emit;
	logic          x_max, z_max, y_max;

	assign in_grid = !pos_x[8] && ({1'b0, pos_x[7:0]} < 9'(vlp_pkg::GRID_WIDTH))
		&& !pos_y[8] && ({1'b0, pos_y[7:0]} < 9'(vlp_pkg::GRID_HEIGHT))
		&& !pos_z[8] && ({1'b0, pos_z[7:0]} < 9'(vlp_pkg::GRID_WIDTH));
	assign in_addr = vlp_pkg::cell_index(pos_x[XB-1:0], pos_y[YB-1:0], pos_z[XB-1:0]);
	assign cell_addr = vlp_pkg::cell_index(x_q, y_q, z_q);
	assign pal_idx_ok = ({1'b0, kind_value} < 9'(vlp_pkg::KIND_COUNT));

	assign clr_cell = cmd.clear_step && ({1'b0, clr_q} < (CLRB+1)'(vlp_pkg::CELL_COUNT));
	assign clr_pal  = cmd.clear_step && ({1'b0, clr_q} < (CLRB+1)'(vlp_pkg::KIND_COUNT));

	assign x_max = (x_q == XB'(vlp_pkg::GRID_WIDTH - 1));
	assign z_max = (z_q == XB'(vlp_pkg::GRID_WIDTH - 1));
	assign y_max = (y_q == YB'(vlp_pkg::GRID_HEIGHT - 1));

	assign cell_solid = kind_ok_q && pal_rd[4];
	assign emit = kind_ok_q ? pal_rd[3:0] : 4'd0;
	assign blk = blocked_q | cell_solid;

	always_comb begin
		nb_in = 1'b0;
		nb_addr = cell_addr;
		case (face_q)
			vlp_pkg::FACE_XP: begin
				nb_in = !x_max;
				nb_addr = cell_addr + CB'(1);
			end
			vlp_pkg::FACE_XN: begin
				nb_in = (x_q != '0);
				nb_addr = cell_addr - CB'(1);
			end
			vlp_pkg::FACE_YP: begin
				nb_in = !y_max;
				nb_addr = cell_addr + CB'(vlp_pkg::GRID_WIDTH * vlp_pkg::GRID_WIDTH);
			end
			vlp_pkg::FACE_YN: begin
				nb_in = (y_q != '0);
				nb_addr = cell_addr - CB'(vlp_pkg::GRID_WIDTH * vlp_pkg::GRID_WIDTH);
			end
			vlp_pkg::FACE_ZP: begin
				nb_in = !z_max;
				nb_addr = cell_addr + CB'(vlp_pkg::GRID_WIDTH);
			end
			vlp_pkg::FACE_ZN: begin
				nb_in = (z_q != '0);
				nb_addr = cell_addr - CB'(vlp_pkg::GRID_WIDTH);
			end
			default: begin
				nb_in = 1'b0;
			end
		endcase
	end

	assign sts.clear_last = (clr_q == CLRB'(vlp_pkg::CLR_COUNT - 1));
	assign sts.sky_last   = (y_q == '0) && x_max && z_max;
	assign sts.here_hi    = (glow_rd > 4'd1);
	assign sts.nb_in      = nb_in;
	assign sts.face_last  = (face_q == vlp_pkg::FACE_ZN);
	assign sts.cell_last  = x_max && z_max && y_max;
	assign sts.pass_last  = (pass_q == PB'(vlp_pkg::PASS_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			pass_q <= '0;
			face_q <= vlp_pkg::FACE_XP;
			blocked_q <= 1'b0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + CLRB'(1);
			if (cmd.accept && opcode == vlp_pkg::OP_RELIGHT) begin
				x_q <= '0;
				z_q <= '0;
				y_q <= YB'(vlp_pkg::GRID_HEIGHT - 1);
				blocked_q <= 1'b0;
			end
			if (cmd.sky_wr) begin
				if (y_q == '0) begin
					y_q <= sts.sky_last ? '0 : YB'(vlp_pkg::GRID_HEIGHT - 1);
					blocked_q <= 1'b0;
					pass_q <= '0;
					if (x_max) begin
						x_q <= '0;
						z_q <= z_max ? '0 : z_q + XB'(1);
					end else begin
						x_q <= x_q + XB'(1);
					end
				end else begin
					y_q <= y_q - YB'(1);
					blocked_q <= blk;
				end
			end
			if (cmd.sp_chk) face_q <= vlp_pkg::FACE_XP;
			if (cmd.adv_face) face_q <= vlp_pkg::face_t'(face_q + 3'd1);
			if (cmd.adv_cell) begin
				if (x_max) begin
					x_q <= '0;
					if (z_max) begin
						z_q <= '0;
						if (y_max) begin
							y_q <= '0;
							pass_q <= pass_q + PB'(1);
						end else begin
							y_q <= y_q + YB'(1);
						end
					end else begin
						z_q <= z_q + XB'(1);
					end
				end else begin
					x_q <= x_q + XB'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sp_chk) next_q <= glow_rd - 4'd1;
		if (cmd.sp_nb) nb_addr_q <= nb_addr;
		if (cmd.sky_pal) kind_ok_q <= (kind_rd != 8'd0) &&
			({1'b0, kind_rd} < 9'(vlp_pkg::KIND_COUNT));
		if (cmd.accept) qin_q <= in_grid;
	end

	always_ff @(posedge clk) begin
		if (clr_cell) begin
			kind_mem[clr_q[CB-1:0]] <= 8'd0;
		end else if (cmd.accept && opcode == vlp_pkg::OP_SET && in_grid) begin
			kind_mem[in_addr] <= kind_value;
		end
		kind_rd <= kind_mem[cmd.accept ? in_addr : cell_addr];
	end

	always_ff @(posedge clk) begin
		if (clr_cell) begin
			sky_mem[clr_q[CB-1:0]] <= vlp_pkg::FULL_LIGHT;
		end else if (cmd.sky_wr) begin
			sky_mem[cell_addr] <= blk ? 4'd0 : vlp_pkg::FULL_LIGHT;
		end
		sky_rd <= sky_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (clr_cell) begin
			glow_mem[clr_q[CB-1:0]] <= 4'd0;
		end else if (cmd.sky_wr) begin
			glow_mem[cell_addr] <= emit;
		end else if (cmd.sp_upd && !solid_rd && glow_rd < next_q) begin
			glow_mem[nb_addr_q] <= next_q;
		end
		glow_rd <= glow_mem[cmd.accept ? in_addr : (cmd.sp_nb ? nb_addr : cell_addr)];
	end

	always_ff @(posedge clk) begin
		if (cmd.sky_wr) solid_mem[cell_addr] <= cell_solid;
		solid_rd <= solid_mem[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (clr_pal) begin
			pal_mem[clr_q[KB-1:0]] <= 5'd0;
		end else if (cmd.accept && opcode == vlp_pkg::OP_PALETTE && pal_idx_ok) begin
			pal_mem[kind_value[KB-1:0]] <= {solid_flag, emission_level};
		end
		pal_rd <= pal_mem[kind_rd[KB-1:0]];
	end

	assign answer_tag = cmd.r_out;
	assign voxel_kind = (cmd.q_out && qin_q) ? kind_rd : 8'd0;
	assign sky_level  = cmd.q_out ? (qin_q ? sky_rd : vlp_pkg::FULL_LIGHT) : 4'd0;
	assign glow_level = (cmd.q_out && qin_q) ? glow_rd : 4'd0;

endmodule

[rtl/voxel_light_propagation.sv]
// Top level of the voxel light propagation block.
// A command beat is taken at a rising edge where start is high and busy is low.
// Opcode 0 writes a palette entry and opcode 1 sets one voxel; both finish
// in the cycle they are taken and give no result, so busy stays low.
// Opcode 3 queries one position: the answer is on the result ports, with
// valid high and answer_tag low, in the cycle after the beat is taken, and
// busy is high while the answer is shown.
// Opcode 2 relights the whole grid. The sky and seeding sweep reads each cell
// through the kind store and then the palette, then writes its sky and block
// light. Then fifteen spread passes follow: each cell's block light is read,
// and for each cell whose block light is above one, each face in turn reads
// the neighbor and, if it lies inside the grid, may write it. At the end one
// beat with answer_tag high and all other fields zero is shown and busy falls.
// After reset the block clears its kind, sky, block light and palette
// stores, one cell per cycle, with busy high. Each result beat stands for
// exactly one cycle, marked by valid; the receiver cannot stall it.
module voxel_light_propagation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic signed [8:0] pos_x,
	input  logic signed [8:0] pos_y,
	input  logic signed [8:0] pos_z,
	input  logic [7:0]        kind_value,
	input  logic              solid_flag,
	input  logic [3:0]        emission_level,
	output logic              valid,
	output logic              answer_tag,
	output logic [7:0]        voxel_kind,
	output logic [3:0]        sky_level,
	output logic [3:0]        glow_level
);

	vlp_pkg::cmd_t cmd;
	vlp_pkg::sts_t sts;

	vlp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.valid  (valid)
	);

	vlp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.kind_value     (kind_value),
		.solid_flag     (solid_flag),
		.emission_level (emission_level),
		.answer_tag     (answer_tag),
		.voxel_kind     (voxel_kind),
		.sky_level      (sky_level),
		.glow_level     (glow_level)
	);

`ifndef SYNTH
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("Result beat lasted more than one cycle.");
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy) else $error("Result beat shown while idle.");
	a_query_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == vlp_pkg::OP_QUERY) |=> (valid && !answer_tag))
		else $error("Query did not answer in the next cycle.");
	a_relight_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && answer_tag) |-> (voxel_kind == 8'd0 && sky_level == 4'd0 &&
		glow_level == 4'd0)) else $error("Relight beat carried nonzero fields.");
`endif

endmodule

[tb/sv/voxel_light_propagation_checker.sv]
// Checker that predicts and compares the result beats of the voxel light block.
module voxel_light_propagation_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        opcode,
	input  logic signed [8:0] pos_x,
	input  logic signed [8:0] pos_y,
	input  logic signed [8:0] pos_z,
	input  logic [7:0]        kind_value,
	input  logic              solid_flag,
	input  logic [3:0]        emission_level,
	input  logic              valid,
	input  logic              answer_tag,
	input  logic [7:0]        voxel_kind,
	input  logic [3:0]        sky_level,
	input  logic [3:0]        glow_level,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic       tag;
		logic [7:0] kind;
		logic [3:0] sky;
		logic [3:0] glow;
	} answer_t;

	logic [7:0] grid_kind [vlp_pkg::CELL_COUNT];
	logic [3:0] grid_sky  [vlp_pkg::CELL_COUNT];
	logic [3:0] grid_glow [vlp_pkg::CELL_COUNT];
	logic       pal_solid [256];
	logic [3:0] pal_emit  [256];
	answer_t    answers_due [$];

	function automatic bit inside_grid(int x, int y, int z);
		return x >= 0 && x < vlp_pkg::GRID_WIDTH && y >= 0 && y < vlp_pkg::GRID_HEIGHT &&
			z >= 0 && z < vlp_pkg::GRID_WIDTH;
	endfunction

	function automatic int addr_of(int x, int y, int z);
		return (y * vlp_pkg::GRID_WIDTH + z) * vlp_pkg::GRID_WIDTH + x;
	endfunction

	function automatic bit blocks_light(logic [7:0] k);
		return k != 0 && int'(k) < vlp_pkg::KIND_COUNT && pal_solid[k];
	endfunction

	function automatic logic [3:0] glow_of(logic [7:0] k);
		if (k == 0 || int'(k) >= vlp_pkg::KIND_COUNT)
			return 4'd0;
		return pal_emit[k];
	endfunction

	task automatic recompute_light();
		int dx [6] = '{1, -1, 0, 0, 0, 0};
		int dy [6] = '{0, 0, 1, -1, 0, 0};
		int dz [6] = '{0, 0, 0, 0, 1, -1};
		logic [3:0] level;
		logic [3:0] here;
		int n;
		for (int c = 0; c < vlp_pkg::CELL_COUNT; c++)
			grid_glow[c] = 4'd0;
		for (int z = 0; z < vlp_pkg::GRID_WIDTH; z++)
			for (int x = 0; x < vlp_pkg::GRID_WIDTH; x++) begin
				level = vlp_pkg::FULL_LIGHT;
				for (int y = vlp_pkg::GRID_HEIGHT - 1; y >= 0; y--) begin
					if (blocks_light(grid_kind[addr_of(x, y, z)]))
						level = 4'd0;
					grid_sky[addr_of(x, y, z)] = level;
				end
			end
		for (int c = 0; c < vlp_pkg::CELL_COUNT; c++)
			if (glow_of(grid_kind[c]) > 0)
				grid_glow[c] = glow_of(grid_kind[c]);
		for (int p = 0; p < vlp_pkg::PASS_COUNT; p++)
			for (int y = 0; y < vlp_pkg::GRID_HEIGHT; y++)
				for (int z = 0; z < vlp_pkg::GRID_WIDTH; z++)
					for (int x = 0; x < vlp_pkg::GRID_WIDTH; x++) begin
						here = grid_glow[addr_of(x, y, z)];
						if (here > 1)
							for (int f = 0; f < 6; f++) begin
								if (inside_grid(x + dx[f], y + dy[f], z + dz[f])) begin
									n = addr_of(x + dx[f], y + dy[f], z + dz[f]);
									if (!blocks_light(grid_kind[n]) && grid_glow[n] < here - 1)
										grid_glow[n] = here - 4'd1;
								end
							end
					end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		for (int c = 0; c < vlp_pkg::CELL_COUNT; c++) begin
			grid_kind[c] = 8'd0;
			grid_sky[c] = vlp_pkg::FULL_LIGHT;
			grid_glow[c] = 4'd0;
		end
		for (int k = 0; k < 256; k++) begin
			pal_solid[k] = 1'b0;
			pal_emit[k] = 4'd0;
		end
	end

	always @(posedge clk) begin
		answer_t seen;
		answer_t due;
		int x, y, z;
		if (arst_n) begin
			if (valid) begin
				seen = '{answer_tag, voxel_kind, sky_level, glow_level};
				if (answers_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat %h", seen);
				end else begin
					due = answers_due.pop_front();
					if (seen !== due) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected tag %0d kind %0d sky %0d glow %0d,",
								" got tag %0d kind %0d sky %0d glow %0d"},
								due.tag, due.kind, due.sky, due.glow,
								seen.tag, seen.kind, seen.sky, seen.glow);
					end
				end
			end
			if (start && !busy) begin
				x = int'(pos_x);
				y = int'(pos_y);
				z = int'(pos_z);
				case (vlp_pkg::op_t'(opcode))
					vlp_pkg::OP_PALETTE: begin
						if (int'(kind_value) < vlp_pkg::KIND_COUNT) begin
							pal_solid[kind_value] = solid_flag;
							pal_emit[kind_value] = emission_level;
						end
					end
					vlp_pkg::OP_SET: begin
						if (inside_grid(x, y, z))
							grid_kind[addr_of(x, y, z)] = kind_value;
					end
					vlp_pkg::OP_RELIGHT: begin
						recompute_light();
						answers_due.push_back('{1'b1, 8'd0, 4'd0, 4'd0});
					end
					default: begin
						if (inside_grid(x, y, z))
							answers_due.push_back('{1'b0, grid_kind[addr_of(x, y, z)],
								grid_sky[addr_of(x, y, z)], grid_glow[addr_of(x, y, z)]});
						else
							answers_due.push_back('{1'b0, 8'd0, vlp_pkg::FULL_LIGHT, 4'd0});
					end
				endcase
			end
		end
		pending = answers_due.size();
	end

endmodule

[tb/sv/voxel_light_propagation_tb.sv]
// Testbench top that drives commands into the voxel light block and reports the verdict.
module voxel_light_propagation_tb;

	localparam int CYCLE_LIMIT = 30000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        opcode = vlp_pkg::OP_QUERY;
	logic signed [8:0] pos_x = '0;
	logic signed [8:0] pos_y = '0;
	logic signed [8:0] pos_z = '0;
	logic [7:0]        kind_value = '0;
	logic              solid_flag = 1'b0;
	logic [3:0]        emission_level = '0;
	logic              valid;
	logic              answer_tag;
	logic [7:0]        voxel_kind;
	logic [3:0]        sky_level;
	logic [3:0]        glow_level;
	int                fail_count;
	int                pending;
	int                cycles = 0;
	bit                calm = 1'b0;

	voxel_light_propagation dut (.*);
	voxel_light_propagation_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic issue(vlp_pkg::op_t op, int x, int y, int z, int k, int s, int e);
		while (!calm && $urandom_range(99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		pos_x <= 9'(x);
		pos_y <= 9'(y);
		pos_z <= 9'(z);
		kind_value <= 8'(k);
		solid_flag <= 1'(s);
		emission_level <= 4'(e);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic int pick_coord();
		if ($urandom_range(9) == 0)
			return int'($signed(9'($urandom())));
		return $urandom_range(vlp_pkg::GRID_WIDTH - 1);
	endfunction

	function automatic int pick_kind();
		if ($urandom_range(9) == 0)
			return $urandom_range(255);
		return $urandom_range(7);
	endfunction

	initial begin
		int r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(vlp_pkg::OP_QUERY, 3, 4, 5, 0, 0, 0);
		issue(vlp_pkg::OP_PALETTE, 0, 0, 0, 0, 1, 15);
		issue(vlp_pkg::OP_PALETTE, 0, 0, 0, 1, 1, 0);
		issue(vlp_pkg::OP_PALETTE, 0, 0, 0, 2, 0, 15);
		issue(vlp_pkg::OP_PALETTE, 0, 0, 0, 3, 1, 7);
		issue(vlp_pkg::OP_PALETTE, 0, 0, 0, 255, 1, 9);
		issue(vlp_pkg::OP_SET, 0, 15, 0, 1, 0, 0);
		issue(vlp_pkg::OP_SET, 15, 0, 15, 255, 0, 0);
		issue(vlp_pkg::OP_SET, 8, 8, 8, 2, 0, 0);
		issue(vlp_pkg::OP_SET, 2, 2, 2, 3, 0, 0);
		issue(vlp_pkg::OP_SET, 5, 5, 5, 0, 0, 0);
		issue(vlp_pkg::OP_SET, -1, 3, 3, 1, 0, 0);
		issue(vlp_pkg::OP_SET, 3, 16, 3, 1, 0, 0);
		issue(vlp_pkg::OP_RELIGHT, 0, 0, 0, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, 0, 15, 0, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, 8, 9, 8, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, 15, 0, 15, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, -256, 0, 0, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, 0, 255, 0, 0, 0, 0);
		issue(vlp_pkg::OP_QUERY, 0, 0, -1, 0, 0, 0);
		issue(vlp_pkg::OP_SET, 8, 9, 8, 1, 0, 0);
		issue(vlp_pkg::OP_QUERY, 8, 9, 8, 0, 0, 0);

		for (int i = 0; i < 1300; i++) begin
			calm = (i >= 400 && i < 700);
			r = $urandom_range(99);
			if (i % 325 == 324)
				issue(vlp_pkg::OP_RELIGHT, pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(255), $urandom_range(1), $urandom_range(15));
			else if (r < 6)
				issue(vlp_pkg::OP_PALETTE, pick_coord(), pick_coord(), pick_coord(),
					pick_kind(), $urandom_range(1),
					($urandom_range(3) == 0) ? $urandom_range(15) : 0);
			else if (r < 50)
				issue(vlp_pkg::OP_SET, pick_coord(), pick_coord(), pick_coord(), pick_kind(),
					$urandom_range(1), $urandom_range(15));
			else
				issue(vlp_pkg::OP_QUERY, pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(255), $urandom_range(1), $urandom_range(15));
		end
		start <= 1'b0;

		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
rtl/vlp_pkg.sv
rtl/vlp_ctrl.sv
rtl/vlp_dp.sv
rtl/voxel_light_propagation.sv
tb/sv/voxel_light_propagation_checker.sv
tb/sv/voxel_light_propagation_tb.sv
